@@ rtl/core/cansr_pkg.sv @@
package cansr_pkg;

  localparam int BYTES_PER_FRAME = 8;
  localparam int WORD_W          = 8 * BYTES_PER_FRAME;
  localparam int ID_W            = 11;
  localparam int CFG_IDX_W       = 2;
  localparam int SCREEN_W        = 8;
  localparam int COUNT_W         = 32;
  localparam int DEF_BUF_BYTES   = 256;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_OPENED    = 3'd1,
    ST_STORED    = 3'd2,
    ST_DONE_OK   = 3'd3,
    ST_CSUM_BAD  = 3'd4,
    ST_REJECTED  = 3'd5,
    ST_SCREEN    = 3'd6,
    ST_RESET_REQ = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALIVE_ID  = 2'd0,
    REG_CONFIG_ID = 2'd1,
    REG_SCREEN_ID = 2'd2,
    REG_RESET_ID  = 2'd3
  } cfg_reg_t;

  function automatic logic [7:0] xor_bytes(input logic [WORD_W-1:0] w);
    logic [7:0] x;
    x = 8'h00;
    for (int i = 0; i < BYTES_PER_FRAME; i++) begin
      x = x ^ w[8*i +: 8];
    end
    return x;
  endfunction

endpackage

@@ rtl/core/can_sequence_reassembler_top.sv @@
// CAN sequence reassembler.
// Input channel (in_valid/in_stall): one received frame per item, frame_id and frame_data.
// Output channel (out_valid/out_stall): result items; last marks the final item of a frame.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): header, screen and reset ids;
// cfg_ready is always high, write only while the block is idle.
// A frame's result is registered and appears in the cycle after acceptance.
// Throughput: one frame per cycle outside playback while results are taken as they appear.
// A passing configuration sequence is played back from the payload memory word by word:
// a read state for the synchronous read, then an emit state that loads the output register
// once it is free. No frame is taken during playback.
// Reset (rst, synchronous) returns to single-frame mode, clears the screen registers and
// frame count and loads the default ids; the payload memory is not cleared, as a sequence
// only reads back words it has written.
// When the receiver stalls, the pending item holds and in_stall rises until it is taken.
// Screen fields and frames_received show the state after the frame that caused the item.
module can_sequence_reassembler_top import cansr_pkg::*; #(
  parameter int BUF_BYTES = DEF_BUF_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ID_W-1:0]      frame_id,
  input  logic [WORD_W-1:0]    frame_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic                 sequence_kind,
  output logic                 payload_valid,
  output logic [WORD_W-1:0]    payload_word,
  output logic                 last,
  output logic [SCREEN_W-1:0]  screen_now,
  output logic [SCREEN_W-1:0]  screen_before,
  output logic [SCREEN_W-1:0]  sub_screen,
  output logic [COUNT_W-1:0]   frames_received,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data
);

  localparam int STORE_WORDS = (BUF_BYTES + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int SW          = $clog2(BUF_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t             state;
  logic [ID_W-1:0]    alive_id, config_id, screen_id, reset_id;
  logic               in_sequence, seq_is_config;
  logic [7:0]         expected_xor, running_xor;
  logic [SW-1:0]      payload_size, bytes_stored;
  logic [SCREEN_W-1:0] screen_reg, prev_screen_reg, sub_screen_reg;
  logic [COUNT_W-1:0] frame_count;
  logic [AW-1:0]      rd_addr, last_addr;

  status_t            out_status;
  logic               out_kind, out_pv, out_last;
  logic [WORD_W-1:0]  out_word;

  logic               accept, out_free, full, wr_en;
  logic [SW-1:0]      remain, size_m1;
  logic [WORD_W-1:0]  masked, wr_word, rd_data;
  logic [7:0]         xor_next;
  logic [AW-1:0]      slot;
  logic [31:0]        hdr_size;
  logic               hit_cfg, hit_alive;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign remain   = payload_size - bytes_stored;
  assign full     = remain > SW'(BYTES_PER_FRAME);
  assign size_m1  = payload_size - 1'b1;
  assign slot     = AW'(bytes_stored >> 3);
  assign hdr_size = frame_data[39:8];
  assign hit_cfg  = (frame_id == config_id);
  assign hit_alive = (frame_id == alive_id);

  // keep only the bytes still owed in the final frame
  always_comb begin
    for (int i = 0; i < BYTES_PER_FRAME; i++) begin
      masked[8*i +: 8] = (SW'(i) < remain) ? frame_data[8*i +: 8] : 8'h00;
    end
  end

  assign wr_word  = full ? frame_data : masked;
  assign xor_next = running_xor ^ xor_bytes(wr_word);
  assign wr_en    = accept && in_sequence && (remain != '0);

  cansr_store #(
    .DEPTH (STORE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (wr_word),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      alive_id        <= ID_W'(0);
      config_id       <= ID_W'(1);
      screen_id       <= ID_W'(2);
      reset_id        <= ID_W'(3);
      in_sequence     <= 1'b0;
      seq_is_config   <= 1'b0;
      expected_xor    <= '0;
      running_xor     <= '0;
      payload_size    <= '0;
      bytes_stored    <= '0;
      screen_reg      <= '0;
      prev_screen_reg <= '0;
      sub_screen_reg  <= '0;
      frame_count     <= '0;
      rd_addr         <= '0;
      last_addr       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ALIVE_ID:  alive_id  <= cfg_data;
          REG_CONFIG_ID: config_id <= cfg_data;
          REG_SCREEN_ID: screen_id <= cfg_data;
          REG_RESET_ID:  reset_id  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            frame_count <= frame_count + 1'b1;
            out_valid   <= 1'b1;
            out_kind    <= 1'b0;
            out_pv      <= 1'b0;
            out_word    <= '0;
            out_last    <= 1'b1;
            if (in_sequence) begin
              out_kind <= seq_is_config;
              if (full) begin
                running_xor  <= xor_next;
                bytes_stored <= bytes_stored + SW'(BYTES_PER_FRAME);
                out_status   <= ST_STORED;
              end else begin
                running_xor  <= xor_next;
                bytes_stored <= bytes_stored + remain;
                in_sequence  <= 1'b0;
                if (xor_next != expected_xor) begin
                  out_status <= ST_CSUM_BAD;
                end else if (seq_is_config && (payload_size != '0)) begin
                  // play back the stored words, no item for this frame yet
                  out_valid <= 1'b0;
                  rd_addr   <= '0;
                  last_addr <= AW'(size_m1 >> 3);
                  state     <= S_READ;
                end else begin
                  out_status <= ST_DONE_OK;
                end
              end
            end else if (hit_cfg || hit_alive) begin
              out_kind <= hit_cfg;
              if (hdr_size > 32'(BUF_BYTES)) begin
                out_status <= ST_REJECTED;
              end else begin
                seq_is_config <= hit_cfg;
                expected_xor  <= frame_data[7:0];
                payload_size  <= SW'(hdr_size);
                bytes_stored  <= '0;
                running_xor   <= '0;
                in_sequence   <= 1'b1;
                out_status    <= ST_OPENED;
              end
            end else if (frame_id == screen_id) begin
              prev_screen_reg <= screen_reg;
              screen_reg      <= frame_data[7:0];
              sub_screen_reg  <= frame_data[15:8];
              out_status      <= ST_SCREEN;
            end else if (frame_id == reset_id) begin
              out_status <= ST_RESET_REQ;
            end else begin
              out_status <= ST_NONE;
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= ST_DONE_OK;
            out_kind   <= 1'b1;
            out_pv     <= 1'b1;
            out_word   <= rd_data;
            out_last   <= (rd_addr == last_addr);
            if (rd_addr == last_addr) begin
              state <= S_IDLE;
            end else begin
              rd_addr <= rd_addr + 1'b1;
              state   <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status          = out_status;
  assign sequence_kind   = out_kind;
  assign payload_valid   = out_pv;
  assign payload_word    = out_word;
  assign last            = out_last;
  assign screen_now      = screen_reg;
  assign screen_before   = prev_screen_reg;
  assign sub_screen      = sub_screen_reg;
  assign frames_received = frame_count;

  a_no_accept_in_playback: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("frame accepted during payload playback");

  a_payload_only_on_config_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && payload_valid) |-> (status == ST_DONE_OK) && sequence_kind)
    else $error("payload word on an item that is not a passing config sequence");

  a_word_zero_without_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !payload_valid) |-> (payload_word == '0))
    else $error("payload word not zero while payload_valid is low");

  a_stored_within_size: assert property (@(posedge clk) disable iff (rst)
    in_sequence |-> (bytes_stored <= payload_size))
    else $error("stored byte count beyond payload size");

endmodule

@@ rtl/core/cansr_store.sv @@
module cansr_store import cansr_pkg::*; #(
  parameter int DEPTH = DEF_BUF_BYTES / BYTES_PER_FRAME,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
